>>> sv/line_follow_pid_steering_top_macros.svh
// ----------------------------------------------------------------------------
// Line follower steering assertion macros
// Concurrent assertion helpers that can be compiled out with ASSERT_OFF.
// ----------------------------------------------------------------------------
`ifndef LINE_FOLLOW_PID_STEERING_TOP_MACROS_SVH
`define LINE_FOLLOW_PID_STEERING_TOP_MACROS_SVH
`ifndef ASSERT_OFF
// Consequent must hold in the same cycle as the antecedent.
`define LFPS_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);
// Consequent must hold in the cycle after the antecedent.
`define LFPS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define LFPS_ASSERT_SAME(label, clk, rst_n, ante, cons, msg)
`define LFPS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`endif
`endif

>>> sv/lfps_pkg.sv
// ----------------------------------------------------------------------------
// Line follower steering package
// Widths, register defaults, register indexes and shared types.
// ----------------------------------------------------------------------------
package lfps_pkg;

	localparam int SENSOR_COUNT = 6;
	localparam int SENSOR_IDX_W = $clog2(SENSOR_COUNT);
	localparam int SAMPLE_W     = 10;
	localparam int SAMPLE_MAX   = (1 << SAMPLE_W) - 1;
	localparam int WEIGHT_STEP  = 1000;

	localparam int TOTAL_W    = $clog2(SENSOR_COUNT * SAMPLE_MAX + 1);
	localparam int SUM_SI_W   = $clog2(SAMPLE_MAX * SENSOR_COUNT * (SENSOR_COUNT - 1) / 2 + 1);
	localparam int WEIGHTED_W = $clog2(SAMPLE_MAX * SENSOR_COUNT * (SENSOR_COUNT - 1) / 2
		* WEIGHT_STEP + 1);

	localparam int KP_W      = 8;
	localparam int KI_W      = 16;
	localparam int KD_W      = 8;
	localparam int DUTY_W    = 10;
	localparam int LEVEL_W   = 10;
	localparam int CENTER_W  = 13;
	localparam int PATTERN_W = 6;
	localparam int ERR_W     = 14;
	localparam int INTEG_W   = 32;
	localparam int ACC_W     = INTEG_W + 2;
	localparam int PID_W     = DUTY_W + 1;

	localparam int CFG_INDEX_W = 3;
	localparam int CFG_DATA_W  = 16;

	localparam int DIV_W     = 32;
	localparam int DIVISOR_W = 16;
	localparam int DIV_STEPS = DIV_W / 2;
	localparam int DIV_CNT_W = $clog2(DIV_STEPS);

	localparam logic [KP_W-1:0]     KP_RESET     = KP_W'(2);
	localparam logic [KI_W-1:0]     KI_RESET     = KI_W'(170);
	localparam logic [KD_W-1:0]     KD_RESET     = KD_W'(20);
	localparam logic [DUTY_W-1:0]   BASE_RESET   = DUTY_W'(900);
	localparam logic [DUTY_W-1:0]   LIMIT_RESET  = DUTY_W'(800);
	localparam logic [LEVEL_W-1:0]  PRES_RESET   = LEVEL_W'(50);
	localparam logic [LEVEL_W-1:0]  BLACK_RESET  = LEVEL_W'(800);
	localparam logic [CENTER_W-1:0] CENTER_RESET = CENTER_W'(2500);

	localparam logic signed [INTEG_W-1:0] INTEG_MAX = {1'b0, {(INTEG_W-1){1'b1}}};
	localparam logic signed [INTEG_W-1:0] INTEG_MIN = {1'b1, {(INTEG_W-1){1'b0}}};
	localparam logic signed [ERR_W-1:0]   ERR_MAX   = {1'b0, {(ERR_W-1){1'b1}}};
	localparam logic signed [ERR_W-1:0]   ERR_MIN   = {1'b1, {(ERR_W-1){1'b0}}};

	typedef logic [SAMPLE_W-1:0] sample_t;

	typedef enum logic [CFG_INDEX_W-1:0] {
		REG_KP,
		REG_KI,
		REG_KD,
		REG_BASE_DUTY,
		REG_CORRECTION_LIMIT,
		REG_PRESENCE_LEVEL,
		REG_BLACK_LEVEL,
		REG_CENTER
	} cfg_reg_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_SCAN,
		ST_CENTROID,
		ST_DIV_POS,
		ST_INTEG,
		ST_DIV_INT,
		ST_DERIV,
		ST_CLAMP,
		ST_MIX
	} ctrl_state_t;

	typedef struct packed {
		logic busy;
		logic done;
	} div_status_t;

endpackage

>>> sv/lfps_scan_if.sv
// ----------------------------------------------------------------------------
// Sensor scan channel
// Valid/ready channel carrying one scan of six reflectance samples.
// ----------------------------------------------------------------------------
interface lfps_scan_if
	import lfps_pkg::*;
;
	logic    valid;
	logic    ready;
	sample_t sample_0;
	sample_t sample_1;
	sample_t sample_2;
	sample_t sample_3;
	sample_t sample_4;
	sample_t sample_5;

	modport source (
		output valid, sample_0, sample_1, sample_2, sample_3, sample_4, sample_5,
		input  ready
	);

	modport sink (
		input  valid, sample_0, sample_1, sample_2, sample_3, sample_4, sample_5,
		output ready
	);
endinterface

>>> sv/lfps_steer_if.sv
// ----------------------------------------------------------------------------
// Steering result channel
// Valid/ready channel carrying the motor duties and line status of one scan.
// ----------------------------------------------------------------------------
interface lfps_steer_if
	import lfps_pkg::*;
;
	logic                     valid;
	logic                     ready;
	logic [DUTY_W-1:0]        right_duty;
	logic [DUTY_W-1:0]        left_duty;
	logic [PATTERN_W-1:0]     line_pattern;
	logic signed [ERR_W-1:0]  line_error;
	logic                     no_line;

	modport source (
		output valid, right_duty, left_duty, line_pattern, line_error, no_line,
		input  ready
	);

	modport sink (
		input  valid, right_duty, left_duty, line_pattern, line_error, no_line,
		output ready
	);
endinterface

>>> sv/lfps_divider.sv
// ----------------------------------------------------------------------------
// Shared unsigned divider
// Restoring divider, two quotient bits per cycle, registered result.
// ----------------------------------------------------------------------------
module lfps_divider
	import lfps_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  logic [DIV_W-1:0]     dividend,
	input  logic [DIVISOR_W-1:0] divisor,
	output logic [DIV_W-1:0]     quotient,
	output div_status_t          status
);

	logic [DIV_W-1:0]     quot_q;
	logic [DIVISOR_W-1:0] rem_q;
	logic [DIVISOR_W-1:0] divisor_q;
	logic [DIV_CNT_W-1:0] count_q;
	logic                 busy_q;
	logic                 done_q;

	logic [DIVISOR_W:0]   rem_a;
	logic [DIVISOR_W:0]   rem_c;
	logic [DIVISOR_W-1:0] rem_b;
	logic [DIVISOR_W-1:0] rem_d;
	logic                 bit_a;
	logic                 bit_b;

	// Two dependent compare-and-subtract steps per cycle.
	always_comb begin
		rem_a = {rem_q, quot_q[DIV_W-1]};
		if (rem_a >= {1'b0, divisor_q}) begin
			rem_b = DIVISOR_W'(rem_a - {1'b0, divisor_q});
			bit_a = 1'b1;
		end else begin
			rem_b = rem_a[DIVISOR_W-1:0];
			bit_a = 1'b0;
		end
		rem_c = {rem_b, quot_q[DIV_W-2]};
		if (rem_c >= {1'b0, divisor_q}) begin
			rem_d = DIVISOR_W'(rem_c - {1'b0, divisor_q});
			bit_b = 1'b1;
		end else begin
			rem_d = rem_c[DIVISOR_W-1:0];
			bit_b = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q  <= 1'b0;
			done_q  <= 1'b0;
			count_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q  <= 1'b1;
				count_q <= '0;
			end else if (busy_q) begin
				count_q <= count_q + 1'b1;
				if (count_q == DIV_CNT_W'(DIV_STEPS - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quot_q    <= dividend;
			rem_q     <= '0;
			divisor_q <= divisor;
		end else if (busy_q) begin
			quot_q <= {quot_q[DIV_W-3:0], bit_a, bit_b};
			rem_q  <= rem_d;
		end
	end

	assign quotient    = quot_q;
	assign status.busy = busy_q;
	assign status.done = done_q;

endmodule

>>> sv/line_follow_pid_steering_top.sv
// ----------------------------------------------------------------------------
// Line follower steering: weighted-centroid line position and PID mixing
// Each scan uses up to two passes of the shared divider, one fewer when a division is skipped.
// A new scan is accepted only once the previous one has been loaded into the output register.
// Reset: arst_n clears control, integral and previous error, and loads register defaults.
// ----------------------------------------------------------------------------
`include "line_follow_pid_steering_top_macros.svh"

module line_follow_pid_steering_top
	import lfps_pkg::*;
(
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_we,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_data,
	lfps_scan_if.sink              scan,
	lfps_steer_if.source           steer
);

	// ------------------------------------------------------------------------
	// Configuration registers. The user must write only while the block is idle;
	// the block does not enforce this, and writes are taken directly with no shadowing.
	// ------------------------------------------------------------------------
	logic [KP_W-1:0]     kp_q;
	logic [KI_W-1:0]     ki_q;
	logic [KD_W-1:0]     kd_q;
	logic [DUTY_W-1:0]   base_q;
	logic [DUTY_W-1:0]   limit_q;
	logic [LEVEL_W-1:0]  pres_q;
	logic [LEVEL_W-1:0]  black_q;
	logic [CENTER_W-1:0] center_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kp_q     <= KP_RESET;
			ki_q     <= KI_RESET;
			kd_q     <= KD_RESET;
			base_q   <= BASE_RESET;
			limit_q  <= LIMIT_RESET;
			pres_q   <= PRES_RESET;
			black_q  <= BLACK_RESET;
			center_q <= CENTER_RESET;
		end else if (cfg_we) begin
			case (cfg_reg_t'(cfg_index))
				REG_KP:               kp_q     <= cfg_data[KP_W-1:0];
				REG_KI:               ki_q     <= cfg_data[KI_W-1:0];
				REG_KD:               kd_q     <= cfg_data[KD_W-1:0];
				REG_BASE_DUTY:        base_q   <= cfg_data[DUTY_W-1:0];
				REG_CORRECTION_LIMIT: limit_q  <= cfg_data[DUTY_W-1:0];
				REG_PRESENCE_LEVEL:   pres_q   <= cfg_data[LEVEL_W-1:0];
				REG_BLACK_LEVEL:      black_q  <= cfg_data[LEVEL_W-1:0];
				REG_CENTER:           center_q <= cfg_data[CENTER_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// ------------------------------------------------------------------------
	// Sequencer. One scan walks the states below in order (a DIV state is skipped if unused):
	//   SCAN      one sensor per cycle from a shift line of the samples
	//   CENTROID  start the centroid division, or take an error of zero when
	//             no sensor sees the line
	//   DIV_POS   wait for the divider, then form the saturated error
	//   INTEG     saturating integral update, proportional term, and start of
	//             the integral division when ki is not zero
	//   DIV_INT   wait for the divider and add the signed integral term
	//   DERIV     add the derivative term and keep the error for next time
	//   CLAMP     clamp the sum to the correction limit
	//   MIX       form the duties into the output register once it is free
	// ------------------------------------------------------------------------
	ctrl_state_t state_q;
	ctrl_state_t state_d;

	logic [SENSOR_IDX_W-1:0] idx_q;
	logic                    present_q;
	logic                    out_valid_q;
	logic                    out_free;
	div_status_t             div_stat;

	logic load_scan;
	logic scan_step;
	logic div_start;
	logic div_sel_integ;
	logic clear_err;
	logic take_err;
	logic take_integ;
	logic take_iterm;
	logic take_deriv;
	logic take_clamp;
	logic mix_load;

	// The output register frees up in the same cycle its item is taken.
	assign out_free = !out_valid_q || steer.ready;

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (scan.valid) begin
					state_d = ST_SCAN;
				end
			end
			ST_SCAN: begin
				if (idx_q == SENSOR_IDX_W'(SENSOR_COUNT - 1)) begin
					state_d = ST_CENTROID;
				end
			end
			ST_CENTROID: begin
				state_d = present_q ? ST_DIV_POS : ST_INTEG;
			end
			ST_DIV_POS: begin
				if (div_stat.done) begin
					state_d = ST_INTEG;
				end
			end
			ST_INTEG: begin
				state_d = (ki_q != '0) ? ST_DIV_INT : ST_DERIV;
			end
			ST_DIV_INT: begin
				if (div_stat.done) begin
					state_d = ST_DERIV;
				end
			end
			ST_DERIV: begin
				state_d = ST_CLAMP;
			end
			ST_CLAMP: begin
				state_d = ST_MIX;
			end
			ST_MIX: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_comb begin
		scan.ready    = 1'b0;
		load_scan     = 1'b0;
		scan_step     = 1'b0;
		div_start     = 1'b0;
		div_sel_integ = 1'b0;
		clear_err     = 1'b0;
		take_err      = 1'b0;
		take_integ    = 1'b0;
		take_iterm    = 1'b0;
		take_deriv    = 1'b0;
		take_clamp    = 1'b0;
		mix_load      = 1'b0;
		case (state_q)
			ST_IDLE: begin
				scan.ready = 1'b1;
				load_scan  = scan.valid;
			end
			ST_SCAN: begin
				scan_step = 1'b1;
			end
			ST_CENTROID: begin
				div_start = present_q;
				clear_err = !present_q;
			end
			ST_DIV_POS: begin
				take_err = div_stat.done;
			end
			ST_INTEG: begin
				take_integ    = 1'b1;
				div_start     = (ki_q != '0);
				div_sel_integ = 1'b1;
			end
			ST_DIV_INT: begin
				take_iterm = div_stat.done;
			end
			ST_DERIV: begin
				take_deriv = 1'b1;
			end
			ST_CLAMP: begin
				take_clamp = 1'b1;
			end
			ST_MIX: begin
				mix_load = out_free;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// ------------------------------------------------------------------------
	// Scan stage. The samples sit in a shift line and sensor 0 is examined
	// first, so shifting each threshold bit in from the bottom leaves sensor 0
	// in the top bit of the pattern. The weighted sum is kept as the sum of
	// sample times sensor index; the factor of 1000 is applied once at the end.
	// ------------------------------------------------------------------------
	sample_t               samp_q [SENSOR_COUNT];
	sample_t               cur_sample;
	logic [PATTERN_W-1:0]  pattern_q;
	logic [TOTAL_W-1:0]    total_q;
	logic [SUM_SI_W-1:0]   sum_si_q;
	logic [WEIGHTED_W-1:0] weighted;

	assign cur_sample = samp_q[0];
	assign weighted   = WEIGHTED_W'(sum_si_q) * WEIGHTED_W'(WEIGHT_STEP);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q     <= '0;
			present_q <= 1'b0;
		end else if (load_scan) begin
			idx_q     <= '0;
			present_q <= 1'b0;
		end else if (scan_step) begin
			idx_q <= idx_q + 1'b1;
			if (cur_sample > pres_q) begin
				present_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load_scan) begin
			samp_q[0] <= scan.sample_0;
			samp_q[1] <= scan.sample_1;
			samp_q[2] <= scan.sample_2;
			samp_q[3] <= scan.sample_3;
			samp_q[4] <= scan.sample_4;
			samp_q[5] <= scan.sample_5;
			pattern_q <= '0;
			total_q   <= '0;
			sum_si_q  <= '0;
		end else if (scan_step) begin
			for (int k = 0; k < SENSOR_COUNT - 1; k++) begin
				samp_q[k] <= samp_q[k+1];
			end
			pattern_q <= {pattern_q[PATTERN_W-2:0], (cur_sample > black_q)};
			if (cur_sample > pres_q) begin
				total_q  <= total_q + TOTAL_W'(cur_sample);
				sum_si_q <= sum_si_q + SUM_SI_W'(cur_sample) * SUM_SI_W'(idx_q);
			end
		end
	end

	// ------------------------------------------------------------------------
	// Shared divider. It first divides the weighted sum by the sample total to
	// find the centroid, then the magnitude of the integral by ki; the sign of
	// the integral is put back afterwards, which gives truncation toward zero.
	// ------------------------------------------------------------------------
	logic signed [INTEG_W-1:0] integ_q;
	logic signed [INTEG_W:0]   integ_sum;
	logic signed [INTEG_W-1:0] integ_next;
	logic [INTEG_W-1:0]        integ_mag;
	logic                      integ_neg_q;
	logic [DIV_W-1:0]          div_dividend;
	logic [DIVISOR_W-1:0]      div_divisor;
	logic [DIV_W-1:0]          div_quot;

	logic signed [ERR_W-1:0]   err_q;
	logic signed [ERR_W-1:0]   prev_q;

	always_comb begin
		integ_sum = (INTEG_W+1)'(integ_q) + (INTEG_W+1)'(err_q);
		if (integ_sum[INTEG_W] != integ_sum[INTEG_W-1]) begin
			integ_next = integ_sum[INTEG_W] ? INTEG_MIN : INTEG_MAX;
		end else begin
			integ_next = integ_sum[INTEG_W-1:0];
		end
		// The most negative integral maps onto its true magnitude as unsigned.
		integ_mag = integ_next[INTEG_W-1] ? INTEG_W'(-integ_next) : INTEG_W'(integ_next);
	end

	assign div_dividend = div_sel_integ ? DIV_W'(integ_mag) : DIV_W'(weighted);
	assign div_divisor  = div_sel_integ ? DIVISOR_W'(ki_q) : DIVISOR_W'(total_q);

	lfps_divider u_divider (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dividend),
		.divisor  (div_divisor),
		.quotient (div_quot),
		.status   (div_stat)
	);

	// ------------------------------------------------------------------------
	// Error and PID terms. The centroid never exceeds the top sensor weight,
	// and its difference with any thirteen-bit center fits the error range;
	// the error is still saturated to its fourteen bits.
	// ------------------------------------------------------------------------
	logic signed [ERR_W:0]           err_wide;
	logic signed [ERR_W-1:0]         err_sat;
	logic signed [ERR_W+KP_W:0]      p_prod;
	logic signed [ERR_W:0]           err_diff;
	logic signed [ERR_W+KD_W+1:0]    d_prod;
	logic signed [ACC_W-1:0]         iterm_pos;
	logic signed [ACC_W-1:0]         iterm;
	logic signed [ACC_W-1:0]         acc_q;
	logic signed [ACC_W-1:0]         lim_w;
	logic signed [PID_W-1:0]         pid_q;

	always_comb begin
		err_wide = $signed({2'b00, div_quot[CENTER_W-1:0]}) - $signed({2'b00, center_q});
		if (err_wide[ERR_W] != err_wide[ERR_W-1]) begin
			err_sat = err_wide[ERR_W] ? ERR_MIN : ERR_MAX;
		end else begin
			err_sat = err_wide[ERR_W-1:0];
		end
	end

	assign p_prod    = (ERR_W+KP_W+1)'(err_q) * (ERR_W+KP_W+1)'($signed({1'b0, kp_q}));
	assign err_diff  = (ERR_W+1)'(err_q) - (ERR_W+1)'(prev_q);
	assign d_prod    = (ERR_W+KD_W+2)'(err_diff) * (ERR_W+KD_W+2)'($signed({1'b0, kd_q}));
	assign iterm_pos = $signed({2'b00, div_quot});
	assign iterm     = integ_neg_q ? -iterm_pos : iterm_pos;
	assign lim_w     = $signed(ACC_W'(limit_q));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			integ_q <= '0;
			prev_q  <= '0;
		end else begin
			if (take_integ) begin
				integ_q <= integ_next;
			end
			if (take_deriv) begin
				prev_q <= err_q;
			end
		end
	end

	// The PID sum is accumulated exactly in a wide register: proportional
	// term first, then the integral term, then the derivative term.
	always_ff @(posedge clk) begin
		if (clear_err) begin
			err_q <= '0;
		end else if (take_err) begin
			err_q <= err_sat;
		end
		if (take_integ) begin
			acc_q       <= ACC_W'(p_prod);
			integ_neg_q <= integ_next[INTEG_W-1];
		end else if (take_iterm) begin
			acc_q <= acc_q + iterm;
		end else if (take_deriv) begin
			acc_q <= acc_q + ACC_W'(d_prod);
		end
		if (take_clamp) begin
			if (acc_q > lim_w) begin
				pid_q <= PID_W'(lim_w);
			end else if (acc_q < -lim_w) begin
				pid_q <= PID_W'(-lim_w);
			end else begin
				pid_q <= acc_q[PID_W-1:0];
			end
		end
	end

	// ------------------------------------------------------------------------
	// Mixing and output register. A positive correction slows the right
	// wheel, a negative one slows the left; the other wheel keeps the base
	// duty. The slowed duty stops at zero. The output register holds a
	// finished item while the sequencer goes back to accept the next scan.
	// ------------------------------------------------------------------------
	logic signed [DUTY_W+1:0] base_s;
	logic signed [DUTY_W+1:0] pid_x;
	logic signed [DUTY_W+1:0] slow_sum;
	logic [DUTY_W-1:0]        slow_duty;
	logic [DUTY_W-1:0]        right_d;
	logic [DUTY_W-1:0]        left_d;

	always_comb begin
		base_s = $signed({2'b00, base_q});
		pid_x  = (DUTY_W+2)'(pid_q);
		if (pid_q > 0) begin
			slow_sum = base_s - pid_x;
		end else begin
			slow_sum = base_s + pid_x;
		end
		slow_duty = (slow_sum < 0) ? '0 : slow_sum[DUTY_W-1:0];
		if (pid_q > 0) begin
			right_d = slow_duty;
			left_d  = base_q;
		end else begin
			right_d = base_q;
			left_d  = slow_duty;
		end
	end

	logic [DUTY_W-1:0]       right_q;
	logic [DUTY_W-1:0]       left_q;
	logic [PATTERN_W-1:0]    out_pattern_q;
	logic signed [ERR_W-1:0] out_error_q;
	logic                    out_no_line_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (mix_load) begin
			out_valid_q <= 1'b1;
		end else if (steer.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (mix_load) begin
			right_q       <= right_d;
			left_q        <= left_d;
			out_pattern_q <= pattern_q;
			out_error_q   <= err_q;
			out_no_line_q <= !present_q;
		end
	end

	assign steer.valid        = out_valid_q;
	assign steer.right_duty   = right_q;
	assign steer.left_duty    = left_q;
	assign steer.line_pattern = out_pattern_q;
	assign steer.line_error   = out_error_q;
	assign steer.no_line      = out_no_line_q;

	// ------------------------------------------------------------------------
	// Assertions
	// ------------------------------------------------------------------------
	`LFPS_ASSERT_NEXT(a_accept_starts_scan, clk, arst_n, scan.valid && scan.ready, state_q == ST_SCAN, "accepted scan did not start the sensor walk")
	`LFPS_ASSERT_SAME(a_div_start_idle, clk, arst_n, div_start, !div_stat.busy, "divider restarted while busy")
	`LFPS_ASSERT_SAME(a_div_done_waited, clk, arst_n, div_stat.done, state_q == ST_DIV_POS || state_q == ST_DIV_INT, "divider finished with no state waiting for it")
	`LFPS_ASSERT_SAME(a_no_line_zero_err, clk, arst_n, steer.valid && steer.no_line, steer.line_error == '0, "no line reported with a non-zero error")
	`LFPS_ASSERT_SAME(a_one_wheel_base, clk, arst_n, steer.valid, steer.right_duty == base_q || steer.left_duty == base_q, "neither wheel runs at the base duty")

endmodule
